// ===== sv/ptp_pkg.sv =====
// Shared types and constants for the pose table proximity block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ptp_pkg;

	// Operation codes carried by an input transfer
	typedef enum logic [1:0] {
		OP_STORE_PEER = 2'd0,
		OP_STORE_OWN  = 2'd1,
		OP_SWEEP      = 2'd2,
		OP_QUERY      = 2'd3
	} opcode_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_SLOT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE_AGE = 1'b1;
	localparam int CFG_DATA_W = 32;

	localparam logic [2:0]  OWN_SLOT_RESET  = 3'd0;
	localparam logic [31:0] STALE_AGE_RESET = 32'd500;

	// Status bits
	localparam int STATUS_VALID = 0;
	localparam int STATUS_STALE = 1;

	// Distance arithmetic
	localparam int FRAC_BITS = 16;
	localparam int DIFF_W    = 33;
	localparam int SQ_IN_W   = 24;
	localparam int SQ_W      = 2 * SQ_IN_W;
	localparam logic [31:0] SUM_CAP = 32'h7FFF_FFFF;

	typedef struct packed {
		opcode_t            opcode;
		logic [7:0]         slot_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        time_ms;
		logic [1:0]         pose_flags;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] range_out;
		logic [1:0]  slot_status;
	} result_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        time_ms;
		logic [1:0]         status;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STORE,
		ST_SWEEP_RD,
		ST_SWEEP_WR,
		ST_Q_OWN_RD,
		ST_Q_PEER_RD,
		ST_Q_DIFF,
		ST_Q_ABS,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SUM,
		ST_ROOT_START,
		ST_ROOT_WAIT,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// ===== sv/ptp_table.sv =====
// Pose table memory: one entry per slot, one read and one write port.
// Depends on ptp_pkg for the entry type.
`default_nettype none

module ptp_table
	import ptp_pkg::*;
#(
	parameter int SLOT_COUNT = 8,
	parameter int SLOT_W = $clog2(SLOT_COUNT)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [SLOT_W-1:0] rd_addr,
	output entry_t                 rd_data,
	input  wire logic              wr_en,
	input  wire logic [SLOT_W-1:0] wr_addr,
	input  wire entry_t            wr_data
);

	entry_t                  mem [SLOT_COUNT];
	entry_t                  rd_data_q;
	logic                    rd_hit_q;
	logic [SLOT_COUNT-1:0]   written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Written flags stand in for a clear of the whole table at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_hit_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== sv/ptp_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on ptp_pkg only by convention of the block; stand-alone arithmetic.
`default_nettype none

module ptp_isqrt
	import ptp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] radicand,
	output logic             busy,
	output logic             done,
	output logic [15:0]      root
);

	logic [31:0] rem_q;
	logic [31:0] res_q;
	logic [31:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] trial;
	logic        fits;

	assign trial = res_q + bit_q;
	assign fits  = rem_q >= trial;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				bit_q  <= 32'h4000_0000;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				bit_q <= bit_q >> 2;
				if (bit_q == 32'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = res_q[15:0];

endmodule

`default_nettype wire

// ===== sv/pose_table_proximity.sv =====
// Top level of the pose table proximity block: control sequencer and distance datapath.
// Depends on ptp_pkg, ptp_table and ptp_isqrt.
`default_nettype none

// Usage
//   Input channel (item_valid / item_stall / item): one transfer carries an opcode
//   and a pose. Output channel (result_valid / result_stall / result): exactly one
//   result transfer per input transfer, in order. Configuration (cfg_write,
//   cfg_index, cfg_data) sets the own slot and the stale age; write it only while
//   no transfer is in flight.
// Steps of each operation, one item at a time:
//   store (peer or own)  table write, then response
//   rejected operation   response only
//   stale sweep          read, then write back, per slot; then response
//   distance query       two table reads, difference, magnitude, two squares, sum,
//                        the 16-step root unit, then response
//   The next input is taken in the first cycle the result is valid.
// All poses sit in one table memory with a registered read; a sweep does
// read-modify-write per slot, so no access to an entry overlaps another.
// Reset clears configuration to own slot 0 and stale age 500 ms and marks every
// slot unwritten, so it reads as all zeros. When the receiver stalls, the result
// holds in the output register; a further input may still be taken, and its
// result waits in the sequencer until the output register is free.

module pose_table_proximity
	import ptp_pkg::*;
#(
	parameter int SLOT_COUNT = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire item_t                item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

	state_t state_q, state_d;

	// Configuration
	logic [2:0]  own_slot_q;
	logic [31:0] stale_age_q;

	// Sequencer and datapath registers
	item_t              item_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  sweep_idx_q;
	result_t            rsp_q;
	logic signed [31:0] own_x_q, own_y_q;
	logic [DIFF_W-1:0]  dx_q, dy_q;
	logic [DIFF_W-1:0]  mag_x_q, mag_y_q;
	logic [SQ_W-1:0]    sq_x_q, sq_y_q;
	logic               sat_x_q, sat_y_q;
	logic [31:0]        radicand_q;
	logic               result_valid_q;
	result_t            result_q;

	// Table port
	logic              tbl_rd_en, tbl_wr_en;
	logic [SLOT_W-1:0] tbl_rd_addr, tbl_wr_addr;
	entry_t            tbl_rd_data, tbl_wr_data;

	// Root unit
	logic        sqrt_start, sqrt_busy, sqrt_done;
	logic [15:0] sqrt_root;

	logic              accept;
	logic              rsp_load;
	logic              id_in_range, own_ok, peer_ok, query_ok;
	logic [SLOT_W-1:0] own_addr;
	logic              stale_hit;
	logic              last_slot;
	logic [31:0]       age;
	logic [SQ_IN_W-1:0] mul_in;
	logic              mul_big;
	logic [SQ_W-1:0]   mul_prod;
	logic [SQ_W-1:0]   sq_sum;
	logic [31:0]       sum_scaled;

	ptp_table #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_W     (SLOT_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd_data),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data)
	);

	ptp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand_q),
		.busy     (sqrt_busy),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Id checks on the incoming transfer
	assign own_addr    = SLOT_W'(own_slot_q);
	assign id_in_range = 32'(item.slot_id) < 32'(SLOT_COUNT);
	assign own_ok      = 32'(own_slot_q) < 32'(SLOT_COUNT);
	assign peer_ok     = id_in_range && (32'(item.slot_id) != 32'(own_slot_q));
	assign query_ok    = id_in_range && own_ok;
	assign accept      = item_valid && !item_stall;

	// Sweep: age wraps modulo 2^32; the own slot and invalid slots are left alone
	assign age       = item_q.time_ms - tbl_rd_data.time_ms;
	assign last_slot = sweep_idx_q == LAST_SLOT;
	assign stale_hit = tbl_rd_data.status[STATUS_VALID]
		&& (32'(sweep_idx_q) != 32'(own_slot_q))
		&& (age > stale_age_q);

	// One shared squarer; a magnitude at or above 2^24 always saturates
	assign mul_in   = (state_q == ST_SQ_X) ? mag_x_q[SQ_IN_W-1:0] : mag_y_q[SQ_IN_W-1:0];
	assign mul_big  = (state_q == ST_SQ_X) ? (|mag_x_q[DIFF_W-1:SQ_IN_W])
		: (|mag_y_q[DIFF_W-1:SQ_IN_W]);
	assign mul_prod = SQ_W'(mul_in) * SQ_W'(mul_in);

	assign sq_sum     = sq_x_q + sq_y_q;
	assign sum_scaled = sq_sum[SQ_W-1:FRAC_BITS];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					unique case (item.opcode)
						OP_STORE_PEER: state_d = peer_ok ? ST_STORE : ST_RESP;
						OP_STORE_OWN:  state_d = own_ok ? ST_STORE : ST_RESP;
						OP_SWEEP:      state_d = ST_SWEEP_RD;
						OP_QUERY:      state_d = query_ok ? ST_Q_OWN_RD : ST_RESP;
						default:       state_d = ST_RESP;
					endcase
				end
			end
			ST_STORE:      state_d = ST_RESP;
			ST_SWEEP_RD:   state_d = ST_SWEEP_WR;
			ST_SWEEP_WR:   state_d = last_slot ? ST_RESP : ST_SWEEP_RD;
			ST_Q_OWN_RD:   state_d = ST_Q_PEER_RD;
			ST_Q_PEER_RD:  state_d = ST_Q_DIFF;
			ST_Q_DIFF:     state_d = ST_Q_ABS;
			ST_Q_ABS:      state_d = ST_SQ_X;
			ST_SQ_X:       state_d = ST_SQ_Y;
			ST_SQ_Y:       state_d = ST_SUM;
			ST_SUM:        state_d = ST_ROOT_START;
			ST_ROOT_START: state_d = ST_ROOT_WAIT;
			ST_ROOT_WAIT: begin
				if (sqrt_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!result_valid_q || !result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		item_stall  = 1'b1;
		tbl_rd_en   = 1'b0;
		tbl_rd_addr = slot_q;
		tbl_wr_en   = 1'b0;
		tbl_wr_addr = slot_q;
		tbl_wr_data = tbl_rd_data;
		sqrt_start  = 1'b0;
		rsp_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: item_stall = 1'b0;
			ST_STORE: begin
				tbl_wr_en           = 1'b1;
				tbl_wr_data.x       = item_q.pos_x;
				tbl_wr_data.y       = item_q.pos_y;
				tbl_wr_data.time_ms = item_q.time_ms;
				tbl_wr_data.status  = item_q.pose_flags;
			end
			ST_SWEEP_RD: begin
				tbl_rd_en   = 1'b1;
				tbl_rd_addr = sweep_idx_q;
			end
			ST_SWEEP_WR: begin
				tbl_wr_en                        = stale_hit;
				tbl_wr_addr                      = sweep_idx_q;
				tbl_wr_data.status[STATUS_STALE] = 1'b1;
			end
			ST_Q_OWN_RD: begin
				tbl_rd_en   = 1'b1;
				tbl_rd_addr = own_addr;
			end
			ST_Q_PEER_RD: tbl_rd_en = 1'b1;
			ST_ROOT_START: sqrt_start = 1'b1;
			ST_RESP: rsp_load = !result_valid_q || !result_stall;
			ST_Q_DIFF, ST_Q_ABS, ST_SQ_X, ST_SQ_Y, ST_SUM, ST_ROOT_WAIT: begin
				item_stall = 1'b1;
			end
			default: item_stall = 1'b1;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			own_slot_q     <= OWN_SLOT_RESET;
			stale_age_q    <= STALE_AGE_RESET;
			sweep_idx_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_OWN_SLOT:  own_slot_q  <= cfg_data[2:0];
					CFG_STALE_AGE: stale_age_q <= cfg_data;
				endcase
			end
			// Restart the sweep at slot 0 on every transfer; advance after each write-back
			if (accept) begin
				sweep_idx_q <= '0;
			end else if (state_q == ST_SWEEP_WR) begin
				sweep_idx_q <= sweep_idx_q + 1'b1;
			end
			if (rsp_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			unique case (item.opcode)
				OP_STORE_PEER: begin
					slot_q <= item.slot_id[SLOT_W-1:0];
					rsp_q  <= '{peer_ok, 16'd0, 2'd0};
				end
				OP_STORE_OWN: begin
					slot_q <= own_addr;
					rsp_q  <= '{own_ok, 16'd0, 2'd0};
				end
				OP_SWEEP: begin
					slot_q <= own_addr;
					rsp_q  <= '{1'b1, 16'd0, 2'd0};
				end
				OP_QUERY: begin
					slot_q <= item.slot_id[SLOT_W-1:0];
					rsp_q  <= '{query_ok, 16'd0, 2'd0};
				end
				default: begin
					slot_q <= own_addr;
					rsp_q  <= '0;
				end
			endcase
		end
		case (state_q)
			ST_Q_PEER_RD: begin
				own_x_q <= tbl_rd_data.x;
				own_y_q <= tbl_rd_data.y;
			end
			ST_Q_DIFF: begin
				dx_q <= {own_x_q[31], own_x_q} - {tbl_rd_data.x[31], tbl_rd_data.x};
				dy_q <= {own_y_q[31], own_y_q} - {tbl_rd_data.y[31], tbl_rd_data.y};
				rsp_q.slot_status <= tbl_rd_data.status;
			end
			ST_Q_ABS: begin
				mag_x_q <= dx_q[DIFF_W-1] ? (DIFF_W'(0) - dx_q) : dx_q;
				mag_y_q <= dy_q[DIFF_W-1] ? (DIFF_W'(0) - dy_q) : dy_q;
			end
			ST_SQ_X: begin
				sq_x_q  <= mul_prod;
				sat_x_q <= mul_big || mul_prod[SQ_W-1];
			end
			ST_SQ_Y: begin
				sq_y_q  <= mul_prod;
				sat_y_q <= mul_big || mul_prod[SQ_W-1];
			end
			ST_SUM: begin
				radicand_q <= (sat_x_q || sat_y_q || sum_scaled[31]) ? SUM_CAP : sum_scaled;
			end
			ST_ROOT_WAIT: begin
				if (sqrt_done) begin
					rsp_q.range_out <= sqrt_root;
				end
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			result_q <= rsp_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// The sequencer never reads and writes the table in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_rd_en && tbl_wr_en))
		else $error("table read and write overlap");

	// The root unit only starts when idle, and only finishes while awaited
	a_root_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_busy)
		else $error("root unit restarted while busy");

	a_root_done_awaited: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == ST_ROOT_WAIT))
		else $error("root result arrived outside the wait state");

	// A new result appears only after the response state
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_RESP))
		else $error("result raised outside the response state");

	// A rejected operation carries no distance and no status
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.accepted) |->
			(result.range_out == 16'd0 && result.slot_status == 2'd0))
		else $error("rejected result carries data");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_pose_table_proximity.sv =====
// Testbench for the pose table proximity block: directed table, then random traffic.
// Checks every result against its typed reply or a predictor of the pose table kept inside this file.
// Depends on ptp_pkg and pose_table_proximity.
module tb_pose_table_proximity;
	import ptp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 8;
	localparam int SETTLE_CYCLES = 40;       // longer than a query, the slowest operation
	localparam int STALL_LIMIT = 3000;       // cycles without any transfer or register write before giving up
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 216;
	localparam logic [63:0] SQ_LIMIT = 64'h0000_8000_0000_0000;  // 2^47

	// One row of the directed table: stimulus, and a typed result where it is obvious
	typedef struct packed {
		item_t   it;
		logic    typed;
		result_t reply;
	} row_t;

	localparam int N_DIRECTED = 25;
	localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// fresh table: zero distance, status empty
		'{'{OP_QUERY, 8'd3, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b1, '{1'b1, 16'd0, 2'd0}},
		// out-of-range query ids are refused
		'{'{OP_QUERY, 8'd255, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b1, '{1'b0, 16'd0, 2'd0}},
		'{'{OP_QUERY, 8'd8, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b1, '{1'b0, 16'd0, 2'd0}},
		// peer store into the own slot, and past the table, is refused
		'{'{OP_STORE_PEER, 8'd0, 32'h1, 32'h1, 32'h5, 2'd1}, 1'b1, '{1'b0, 16'd0, 2'd0}},
		'{'{OP_STORE_PEER, 8'd200, 32'h1, 32'h1, 32'h5, 2'd1}, 1'b1, '{1'b0, 16'd0, 2'd0}},
		// own store ignores the id; put our pose at the positive corner
		'{'{OP_STORE_OWN, 8'd255, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 2'd3}, 1'b1,
			'{1'b1, 16'd0, 2'd0}},
		// peer at the negative corner with the last timestamp
		'{'{OP_STORE_PEER, 8'd7, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 2'd1}, 1'b1,
			'{1'b1, 16'd0, 2'd0}},
		// corner to corner: squares overflow, distance saturates
		'{'{OP_QUERY, 8'd7, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b1, '{1'b1, 16'd46340, 2'd1}},
		'{'{OP_STORE_PEER, 8'd1, 32'h0, 32'h0, 32'd100, 2'd1}, 1'b1, '{1'b1, 16'd0, 2'd0}},
		'{'{OP_QUERY, 8'd1, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b1, '{1'b1, 16'd46340, 2'd1}},
		// own at (3 m, 4 m): a 5 m distance gives 5 * 256 in root units
		'{'{OP_STORE_OWN, 8'd0, 32'h0003_0000, 32'h0004_0000, 32'd100, 2'd1}, 1'b1,
			'{1'b1, 16'd0, 2'd0}},
		'{'{OP_QUERY, 8'd1, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b1, '{1'b1, 16'd1280, 2'd1}},
		// sweep: age of exactly the limit stays fresh, a wrapped age of 601 goes stale
		'{'{OP_SWEEP, 8'd0, 32'h0, 32'h0, 32'd600, 2'd0}, 1'b1, '{1'b1, 16'd0, 2'd0}},
		'{'{OP_QUERY, 8'd1, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b1, '{1'b1, 16'd1280, 2'd1}},
		'{'{OP_QUERY, 8'd7, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b1, '{1'b1, 16'd46340, 2'd3}},
		'{'{OP_SWEEP, 8'd5, 32'h0, 32'h0, 32'd601, 2'd3}, 1'b1, '{1'b1, 16'd0, 2'd0}},
		'{'{OP_QUERY, 8'd1, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b1, '{1'b1, 16'd1280, 2'd3}},
		// slots without the valid bit are skipped by a sweep
		'{'{OP_STORE_PEER, 8'd2, 32'hFFFF_0000, 32'h0, 32'h0, 2'd0}, 1'b1,
			'{1'b1, 16'd0, 2'd0}},
		'{'{OP_STORE_PEER, 8'd3, 32'hFFFF_FFFF, 32'h1, 32'h0, 2'd2}, 1'b1,
			'{1'b1, 16'd0, 2'd0}},
		'{'{OP_SWEEP, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 2'd0}, 1'b1, '{1'b1, 16'd0, 2'd0}},
		'{'{OP_QUERY, 8'd2, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b0, '0},
		'{'{OP_QUERY, 8'd3, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b0, '0},
		// distance to ourselves
		'{'{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b1, '{1'b1, 16'd0, 2'd1}},
		// squares below the overflow bound, but their scaled sum above the cap
		'{'{OP_STORE_PEER, 8'd5, 32'h00B3_0000, 32'h00B4_0000, 32'd50, 2'd1}, 1'b1,
			'{1'b1, 16'd0, 2'd0}},
		'{'{OP_QUERY, 8'd5, 32'h0, 32'h0, 32'h0, 2'd0}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	// Predictor copy of the block's state and configuration
	logic signed [31:0] pose_x [SLOTS];
	logic signed [31:0] pose_y [SLOTS];
	logic [31:0] pose_t [SLOTS];
	logic [1:0] pose_st [SLOTS];
	logic [2:0] own_idx;
	logic [31:0] stale_limit;

	result_t replies_due [$];
	int mismatches = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic [31:0] now_ms;

	pose_table_proximity #(.SLOT_COUNT(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Floor root of the scaled squared distance between two slots, saturated
	function automatic logic [15:0] pose_range(input logic [2:0] a, input logic [2:0] b);
		longint dx, dy;
		logic [63:0] mag, sqx, sqy, sum, cand;
		logic [15:0] root;
		dx = longint'(pose_x[a]) - longint'(pose_x[b]);
		dy = longint'(pose_y[a]) - longint'(pose_y[b]);
		mag = (dx < 0) ? -dx : dx;
		sqx = mag * mag;
		mag = (dy < 0) ? -dy : dy;
		sqy = mag * mag;
		// either square at or past 2^47 already puts the scaled sum past the cap
		if (sqx >= SQ_LIMIT || sqy >= SQ_LIMIT) begin
			sum = 64'(SUM_CAP);
		end else begin
			sum = (sqx + sqy) >> FRAC_BITS;
			if (sum > 64'(SUM_CAP))
				sum = 64'(SUM_CAP);
		end
		// build the root one bit at a time, keeping each bit whose square still fits
		root = '0;
		for (int k = 15; k >= 0; k--) begin
			cand = 64'(root | (16'd1 << k));
			if (cand * cand <= sum)
				root = cand[15:0];
		end
		return root;
	endfunction

	// Apply one operation to the predicted table and return the result it yields
	function automatic result_t apply_to_table(input item_t it);
		result_t r;
		logic [2:0] dest;
		logic [31:0] age;
		r = '0;
		case (it.opcode)
		OP_STORE_PEER, OP_STORE_OWN: begin
			dest = (it.opcode == OP_STORE_OWN) ? own_idx : it.slot_id[2:0];
			if (it.opcode == OP_STORE_OWN ||
					(it.slot_id < SLOTS && it.slot_id[2:0] != own_idx)) begin
				pose_x[dest] = it.pos_x;
				pose_y[dest] = it.pos_y;
				pose_t[dest] = it.time_ms;
				pose_st[dest] = it.pose_flags;
				r.accepted = 1'b1;
			end
		end
		OP_SWEEP: begin
			for (int i = 0; i < SLOTS; i++) begin
				if (i != own_idx && pose_st[i][STATUS_VALID]) begin
					age = it.time_ms - pose_t[i];
					if (age > stale_limit)
						pose_st[i][STATUS_STALE] = 1'b1;
				end
			end
			r.accepted = 1'b1;
		end
		default: begin
			if (it.slot_id < SLOTS) begin
				r.range_out = pose_range(own_idx, it.slot_id[2:0]);
				r.slot_status = pose_st[it.slot_id[2:0]];
				r.accepted = 1'b1;
			end
		end
		endcase
		return r;
	endfunction

	// Coordinates: half within 8 metres, three in ten within 128 metres, the rest anywhere
	function automatic logic [31:0] pick_coord();
		logic [31:0] v;
		int unsigned roll;
		v = $urandom;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			v = {{12{v[19]}}, v[19:0]};
		else if (roll < 8)
			v = {{8{v[23]}}, v[23:0]};
		return v;
	endfunction

	// Random operation around a running clock so ages straddle the stale limit
	function automatic item_t make_pose_item();
		item_t it;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			it.opcode = OP_STORE_PEER;
		else if (roll < 50)
			it.opcode = OP_STORE_OWN;
		else if (roll < 65)
			it.opcode = OP_SWEEP;
		else
			it.opcode = OP_QUERY;
		// mostly real slots; now and then any id, out-of-range ones included
		it.slot_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
		it.pos_x = pick_coord();
		it.pos_y = pick_coord();
		now_ms = now_ms + 32'($urandom_range(0, 300));
		if ($urandom_range(0, 6) == 0)
			it.time_ms = $urandom;
		else if (it.opcode == OP_SWEEP)
			it.time_ms = now_ms;
		else
			it.time_ms = now_ms - 32'($urandom_range(0, 1200));
		it.pose_flags = ($urandom_range(0, 9) < 7) ? 2'd1 : 2'($urandom);
		return it;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		mismatches++;
	endtask

	// Offer one item, hold it until the transfer, then record what it must produce
	task automatic send_item(input item_t it, input logic typed, input result_t reply);
		result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		predicted = apply_to_table(it);
		replies_due.push_back(typed ? reply : predicted);
	endtask

	// Drop valid and hold off until every result is back and the block has settled
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; the block is idle here
	task automatic load_config(input logic [2:0] slot, input logic [31:0] age);
		cfg_write <= 1'b1;
		cfg_index <= CFG_OWN_SLOT;
		cfg_data <= 32'(slot);
		@(posedge clk);
		cfg_index <= CFG_STALE_AGE;
		cfg_data <= age;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		own_idx = slot;
		stale_limit = age;
	endtask

	// Receiver back-pressure, redrawn every cycle
	always @(posedge clk)
		result_stall <= ($urandom_range(0, 99) < stall_pct);

	// Check each result transfer against the oldest outstanding expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (replies_due.size() == 0) begin
				flag_mismatch($sformatf("result %0d arrived with nothing outstanding",
					results_seen));
			end else begin
				want = replies_due.pop_front();
				if (result.accepted !== want.accepted || result.range_out !== want.range_out ||
						result.slot_status !== want.slot_status)
					flag_mismatch($sformatf(
						"result %0d: accepted %b/%b range %0d/%0d status %0d/%0d (got/want)",
						results_seen, result.accepted, want.accepted, result.range_out,
						want.range_out, result.slot_status, want.slot_status));
			end
			results_seen++;
		end
	end

	// Watchdog: any transfer or register write counts as progress
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [2:0] phase_slot [PHASES];
		logic [31:0] phase_age [PHASES];
		phase_slot = '{3'd7, 3'd3, 3'd0, 3'd5, 3'd1, 3'd6};
		phase_age = '{32'd0, 32'hFFFF_FFFF, 32'd500, 32'd250, 32'($urandom_range(1, 1000)),
			32'd800};

		// Predictor starts from the reset state
		for (int i = 0; i < SLOTS; i++) begin
			pose_x[i] = '0;
			pose_y[i] = '0;
			pose_t[i] = '0;
			pose_st[i] = '0;
		end
		own_idx = OWN_SLOT_RESET;
		stale_limit = STALE_AGE_RESET;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset configuration, sender lightly idle
		send_idle_pct = 19;
		stall_pct = 85;
		foreach (DIRECTED_ROWS[r])
			send_item(DIRECTED_ROWS[r].it, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].reply);

		// Random phases: a new configuration each, idling pattern changes every two
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			load_config(phase_slot[p], phase_age[p]);
			case (p / 2)
			0: begin
				send_idle_pct = 19;
				stall_pct = 85;
			end
			1: begin
				send_idle_pct = 85;
				stall_pct = 19;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			endcase
			now_ms = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// halfway through, let the pipeline empty completely before going on
				if (n == PHASE_ITEMS / 2)
					wait_drained();
				send_item(make_pose_item(), 1'b0, '0);
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ptp_pkg.sv
sv/ptp_table.sv
sv/ptp_isqrt.sv
sv/pose_table_proximity.sv
tb/tb_pose_table_proximity.sv
